### src/qfr_pkg.sv
// shared constants and types for the binary128 remainder unit
package qfr_pkg;
	localparam int unsigned EXP_BITS_DEF  = 15;
	localparam int unsigned FRAC_BITS_DEF = 112;
	localparam int unsigned WORD_BITS     = 64;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_EXT,
		ST_ROUND,
		ST_NORM,
		ST_DONE
	} qfr_state_t;
endpackage

### src/quad_float_remainder_unit.sv
// IEEE 754 remainder of two binary floating-point operands, default binary128.
// One operation at a time: after a beat is taken the unit is busy until the
// result beat leaves. A single subtract-and-compare unit does one quotient bit
// per cycle: first the FRAC_BITS+1 bits of the significand of x, then one bit
// per unit of exponent difference (ex - ey), followed by rounding and
// normalising shifts; special operands and tiny x skip the division. The result
// sits in an output register.
module quad_float_remainder_unit #(
	parameter int unsigned EXP_BITS  = qfr_pkg::EXP_BITS_DEF,
	parameter int unsigned FRAC_BITS = qfr_pkg::FRAC_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [qfr_pkg::WORD_BITS-1:0]  x_high,
	input  logic [qfr_pkg::WORD_BITS-1:0]  x_low,
	input  logic [qfr_pkg::WORD_BITS-1:0]  y_high,
	input  logic [qfr_pkg::WORD_BITS-1:0]  y_low,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [qfr_pkg::WORD_BITS-1:0]  rem_high,
	output logic [qfr_pkg::WORD_BITS-1:0]  rem_low,
	output logic                           invalid_flag
);
	import qfr_pkg::*;

	localparam int unsigned TOT = 1 + EXP_BITS + FRAC_BITS;
	localparam int unsigned MW  = FRAC_BITS + 2;	// holds 2*divisor
	localparam int unsigned CW  = $clog2(FRAC_BITS + 2);
	localparam logic [EXP_BITS-1:0] EMAX = {EXP_BITS{1'b1}};
	localparam logic [EXP_BITS-1:0] EONE = EXP_BITS'(1);

	qfr_state_t state_q, state_d;

	logic [MW-1:0]       r_q, div_q;
	logic [FRAC_BITS:0]  mx_q;
	logic [EXP_BITS-1:0] cnt_q;	// remaining extra steps
	logic [CW-1:0]       bit_q;
	logic [EXP_BITS-1:0] sexp_q;
	logic                qlast_q, sx_q, sgn_q;
	logic [2*WORD_BITS-1:0] res_q;
	logic                inv_q;

	logic [2*WORD_BITS-1:0] xin, yin;
	logic                   sx;
	logic [EXP_BITS-1:0]    ex, ey, exa, eya;
	logic [FRAC_BITS-1:0]   fx, fy;
	logic                   fyz;

	assign xin = {x_high, x_low};
	assign yin = {y_high, y_low};
	assign sx  = xin[TOT-1];
	assign ex  = xin[FRAC_BITS +: EXP_BITS];
	assign ey  = yin[FRAC_BITS +: EXP_BITS];
	assign fx  = xin[FRAC_BITS-1:0];
	assign fy  = yin[FRAC_BITS-1:0];
	assign fyz = (fy == '0);
	assign exa = (ex == '0) ? EONE : ex;
	assign eya = (ey == '0) ? EONE : ey;

	// shared shift-compare-subtract unit
	logic [MW-1:0] sh_in, sh_r, sub_r;
	logic          ge;
	always_comb begin
		sh_in = (state_q == ST_DIV) ? {r_q[MW-2:0], mx_q[bit_q]} : {r_q[MW-2:0], 1'b0};
		ge    = (sh_in >= div_q);
		sub_r = sh_in - div_q;
		sh_r  = ge ? sub_r : sh_in;
	end

	logic [MW:0] r2;
	assign r2 = {r_q, 1'b0};

	logic [2*WORD_BITS-1:0] nan_w, xm_w;
	assign nan_w = (2*WORD_BITS)'({1'b0, EMAX, 1'b1, {(FRAC_BITS-1){1'b0}}});
	assign xm_w  = (2*WORD_BITS)'(xin[TOT-1:0]);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:  if (in_valid) begin
				if ((ex == EMAX) || (ey == EMAX) || (ey == '0 && fyz)) state_d = ST_DONE;
				else if (exa >= eya) state_d = ST_DIV;
				else if (eya - exa == EONE) state_d = ST_ROUND;
				else state_d = ST_DONE;
			end
			ST_DIV:   if (bit_q == '0) state_d = (cnt_q == '0) ? ST_ROUND : ST_EXT;
			ST_EXT:   if (cnt_q == EONE) state_d = ST_ROUND;
			ST_ROUND: state_d = ST_NORM;
			ST_NORM:  if (r_q == '0 || r_q[FRAC_BITS] || sexp_q <= EONE) state_d = ST_DONE;
			ST_DONE:  if (out_ready) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: if (in_valid) begin
				sx_q    <= sx;
				mx_q    <= {(ex != '0), fx};
				bit_q   <= CW'(FRAC_BITS);
				qlast_q <= 1'b0;
				if (ex == EMAX || (ey == EMAX && !fyz) || (ey == '0 && fyz)) begin
					res_q <= nan_w;
					inv_q <= 1'b1;
				end else begin
					res_q <= xm_w;
					inv_q <= 1'b0;
					if (exa >= eya) begin
						r_q    <= '0;
						div_q  <= MW'({(ey != '0), fy});
						cnt_q  <= exa - eya;
						sexp_q <= eya;
					end else begin
						r_q    <= MW'({(ex != '0), fx});
						div_q  <= MW'({(ey != '0), fy, 1'b0});
						sexp_q <= exa;
					end
				end
			end
			ST_DIV: begin
				r_q     <= sh_r;
				qlast_q <= ge;
				bit_q   <= bit_q - CW'(1);
			end
			ST_EXT: begin
				r_q     <= sh_r;
				qlast_q <= ge;
				cnt_q   <= cnt_q - EONE;
			end
			ST_ROUND: begin
				if (r2 > {1'b0, div_q} || (r2 == {1'b0, div_q} && qlast_q)) begin
					r_q   <= div_q - r_q;
					sgn_q <= ~sx_q;
				end else begin
					sgn_q <= sx_q;
				end
			end
			ST_NORM: begin
				if (r_q == '0) begin
					res_q <= (2*WORD_BITS)'({sx_q, {(TOT-1){1'b0}}});
				end else if (r_q[FRAC_BITS] || sexp_q <= EONE) begin
					res_q <= (2*WORD_BITS)'({sgn_q,
						(r_q[FRAC_BITS] ? sexp_q : {EXP_BITS{1'b0}}),
						r_q[FRAC_BITS-1:0]});
				end else begin
					r_q    <= {r_q[MW-2:0], 1'b0};
					sexp_q <= sexp_q - EONE;
				end
			end
			default: ;
		endcase
	end

	assign in_ready     = (state_q == ST_IDLE);
	assign out_valid    = (state_q == ST_DONE);
	assign rem_high     = res_q[2*WORD_BITS-1:WORD_BITS];
	assign rem_low      = res_q[WORD_BITS-1:0];
	assign invalid_flag = inv_q;

	// a taken beat always moves the unit out of idle
	a_take: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready) else $error("beat taken but still idle");
	// never ready for input while a result is held
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid)) else $error("ready while result pending");
	// result leaves to idle
	a_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready |=> in_ready) else $error("no return to idle");
endmodule

### tb/quad_float_remainder_unit_tb.sv
// self-checking testbench for the binary128 remainder unit
module quad_float_remainder_unit_tb;
	import qfr_pkg::*;

	localparam int unsigned EB = EXP_BITS_DEF;
	localparam int unsigned FB = FRAC_BITS_DEF;
	localparam int unsigned TB = 1 + EB + FB;
	localparam int EMAX = (1 << EB) - 1;

	typedef struct packed {
		logic [WORD_BITS-1:0] hi;
		logic [WORD_BITS-1:0] lo;
		logic                 inv;
	} rem_beat_t;

	// exact remainder by long division over the exponent difference
	function automatic rem_beat_t remainder_of(logic [127:0] xw, logic [127:0] yw);
		logic [127:0] x, y, mx, my, r, dv, hid, res;
		int ex, ey, d, sexp, p;
		logic sx, qlast, flip;
		rem_beat_t o;
		x = xw;
		y = yw;
		if (TB < 128) begin
			x = x & ((128'd1 << TB) - 128'd1);
			y = y & ((128'd1 << TB) - 128'd1);
		end
		hid = 128'd1 << FB;
		sx = x[TB-1];
		ex = int'((x >> FB) & EMAX);
		ey = int'((y >> FB) & EMAX);
		mx = x & (hid - 128'd1);
		my = y & (hid - 128'd1);
		qlast = 1'b0;
		flip = 1'b0;
		o.inv = 1'b0;
		if (ex == EMAX || (ey == EMAX && my != 0) || (ey == 0 && my == 0)) begin
			res = (128'(EMAX) << FB) | (128'd1 << (FB - 1));
			o.hi = res[127:64];
			o.lo = res[63:0];
			o.inv = 1'b1;
			return o;
		end
		if (ey == EMAX) begin
			o.hi = x[127:64];
			o.lo = x[63:0];
			return o;
		end
		if (ex != 0) mx = mx | hid;
		if (ey != 0) my = my | hid;
		if (ex == 0) ex = 1;
		if (ey == 0) ey = 1;
		if (ex >= ey) begin
			d = ex - ey;
			r = '0;
			for (int i = FB; i >= 0; i--) begin
				r = (r << 1) | 128'(mx[i]);
				if (r >= my) begin r = r - my; qlast = 1'b1; end else qlast = 1'b0;
			end
			for (int i = 0; i < d; i++) begin
				r = r << 1;
				if (r >= my) begin r = r - my; qlast = 1'b1; end else qlast = 1'b0;
			end
			dv = my;
			sexp = ey;
		end else if (ey - ex == 1) begin
			r = mx;
			dv = my << 1;
			sexp = ex;
		end else begin
			o.hi = x[127:64];
			o.lo = x[63:0];
			return o;
		end
		if ((r << 1) > dv || ((r << 1) == dv && qlast)) begin
			r = dv - r;
			flip = 1'b1;
		end
		if (r == 0) begin
			res = 128'(sx) << (TB - 1);
		end else begin
			p = -1;
			for (int i = 127; i >= 0; i--)
				if (p < 0 && r[i]) p = i;
			while (p < int'(FB) && sexp > 1) begin
				r = r << 1;
				p++;
				sexp--;
			end
			res = (128'(sx ^ flip) << (TB - 1)) | (r & (hid - 128'd1));
			if (r[FB]) res = res | (128'(sexp) << FB);
		end
		o.hi = res[127:64];
		o.lo = res[63:0];
		return o;
	endfunction

	class rem_scoreboard;
		rem_beat_t pending[$];
		int errors = 0;
		int checked = 0;

		function void note_operands(logic [127:0] xw, logic [127:0] yw);
			pending.push_back(remainder_of(xw, yw));
		endfunction

		function void check_result(logic [63:0] hi, logic [63:0] lo, logic inv);
			rem_beat_t e;
			if (pending.size() == 0) begin
				$error("result beat with nothing pending: %h_%h inv %b", hi, lo, inv);
				errors++;
				return;
			end
			e = pending.pop_front();
			checked++;
			if (hi !== e.hi) begin
				$error("rem_high expected %h got %h", e.hi, hi);
				errors++;
			end
			if (lo !== e.lo) begin
				$error("rem_low expected %h got %h", e.lo, lo);
				errors++;
			end
			if (inv !== e.inv) begin
				$error("invalid_flag expected %b got %b", e.inv, inv);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid, in_ready, out_valid, out_ready, invalid_flag;
	logic [WORD_BITS-1:0] x_high, x_low, y_high, y_low, rem_high, rem_low;

	rem_scoreboard sb = new();
	int sent = 0;
	int nan_seen = 0;
	int hold_left = 0;
	int gap_left = 0;
	bit quiet_phase = 1'b0;

	quad_float_remainder_unit dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.x_high(x_high), .x_low(x_low), .y_high(y_high), .y_low(y_low),
		.out_valid(out_valid), .out_ready(out_ready),
		.rem_high(rem_high), .rem_low(rem_low), .invalid_flag(invalid_flag)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// mostly short gaps, a few long ones
	function automatic int pick_gap();
		int k;
		k = $urandom_range(0, 99);
		if (quiet_phase || k < 50) return 0;
		if (k < 90) return $urandom_range(1, 3);
		return $urandom_range(5, 40);
	endfunction

	function automatic logic [127:0] pack(int s, int e, logic [111:0] f);
		return {s[0], e[14:0], f};
	endfunction

	function automatic logic [111:0] rand_frac();
		return 112'({$urandom, $urandom, $urandom, $urandom});
	endfunction

	task automatic send_beat(logic [127:0] xw, logic [127:0] yw);
		int g;
		g = pick_gap();
		repeat (g) @(negedge clk) in_valid = 1'b0;
		if (g > 0 || !in_valid) @(negedge clk);
		in_valid = 1'b1;
		{x_high, x_low} = xw;
		{y_high, y_low} = yw;
		do @(posedge clk); while (!in_ready);
		sb.note_operands(xw, yw);
		sent++;
		@(negedge clk) in_valid = 1'b0;
	endtask

	// receiver: own ready pattern plus one long hold-off
	always @(negedge clk) begin
		if (!arst_n) begin
			out_ready = 1'b0;
		end else if (hold_left > 0) begin
			out_ready = 1'b0;
			hold_left--;
		end else if (gap_left > 0) begin
			out_ready = 1'b0;
			gap_left--;
		end else begin
			out_ready = 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (invalid_flag) nan_seen++;
			sb.check_result(rem_high, rem_low, invalid_flag);
			gap_left = pick_gap();
			if (sb.checked == 300) hold_left = 600;
		end
	end

	task automatic random_beat();
		int k, ex, ey;
		logic [111:0] fx, fy;
		k = $urandom_range(0, 99);
		fx = rand_frac();
		fy = rand_frac();
		if ($urandom_range(0, 9) == 0) fx = fx & 112'hFFFF << 96;
		if ($urandom_range(0, 9) == 0) fy = fy & 112'hF << 108;
		if (k < 72) begin
			ex = $urandom_range(1, EMAX - 1);
			if ($urandom_range(0, 299) == 0) ey = $urandom_range(1, ex);
			else if ($urandom_range(0, 9) == 0) ey = ex + $urandom_range(1, 3);
			else ey = ex - $urandom_range(0, 120);
			if (ey < 0) ey = 0;
			if (ey > EMAX - 1) ey = EMAX - 1;
			if (ey == 0 && fy == 0) fy = 112'd1;
		end else if (k < 88) begin
			ex = $urandom_range(0, 3);
			ey = $urandom_range(0, 3);
			if ($urandom_range(0, 1)) fx = fx >> $urandom_range(0, 111);
			if ($urandom_range(0, 1)) fy = fy >> $urandom_range(0, 111);
			if (ey == 0 && fy == 0) fy = 112'd1;
		end else begin
			ex = $urandom_range(0, 1) ? EMAX : $urandom_range(0, EMAX);
			ey = $urandom_range(0, 1) ? EMAX : $urandom_range(0, 2);
			if ($urandom_range(0, 1)) fx = '0;
			if ($urandom_range(0, 1)) fy = '0;
		end
		send_beat(pack($urandom_range(0, 1), ex, fx), pack($urandom_range(0, 1), ey, fy));
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		out_ready = 1'b0;
		x_high = '0;
		x_low = '0;
		y_high = '0;
		y_low = '0;
		repeat (12) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// special operands and exact edge cases
		send_beat(pack(0, 0, 112'd0), pack(0, 0, 112'd0));
		send_beat(pack(0, EMAX, 112'd1 << 111), pack(0, 16383, 112'd0));
		send_beat(pack(1, 16383, 112'd0), pack(0, EMAX, 112'd1));
		send_beat(pack(0, EMAX, 112'd0), pack(0, 16383, 112'd0));
		send_beat(pack(1, 16390, rand_frac()), pack(1, 0, 112'd0));
		send_beat(pack(1, 16390, rand_frac()), pack(0, EMAX, 112'd0));
		send_beat(pack(0, 0, 112'd0), pack(0, 16383, 112'd0));
		send_beat(pack(1, 0, 112'd0), pack(1, 5, 112'd3));
		send_beat(pack(0, 16384, 112'd1 << 110), pack(0, 16383, 112'd0));
		send_beat(pack(0, 16384, 112'd3 << 110), pack(0, 16383, 112'd0));
		send_beat(pack(1, 16384, 112'd3 << 110), pack(0, 16383, 112'd0));
		send_beat(pack(0, 16383, 112'd0), pack(0, 16384, 112'd0));
		send_beat(pack(0, 16383, 112'd1 << 111), pack(0, 16384, 112'd0));
		send_beat(pack(0, 0, 112'd5), pack(0, 0, 112'd3));
		send_beat(pack(1, 0, {112{1'b1}}), pack(0, 0, 112'd1));
		send_beat(pack(0, 1, 112'd0), pack(0, 16383, 112'd0));
		send_beat(pack(1, 16400, 112'h1234), pack(1, 16400, 112'h1234));
		send_beat(pack(0, EMAX - 1, {112{1'b1}}), pack(0, 0, 112'd1));
		send_beat(pack(1, EMAX - 1, {112{1'b1}}), pack(1, EMAX - 1, {112{1'b1}}));
		send_beat(pack(0, 1, {112{1'b1}}), pack(0, 0, {112{1'b1}}));

		for (int i = 0; i < 1100; i++) begin
			if (i % 150 == 0) quiet_phase = ($urandom_range(0, 2) == 0);
			random_beat();
		end
		quiet_phase = 1'b0;

		while (sb.pending.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		$display("sent %0d operand pairs, checked %0d remainders (%0d default NaN)",
			sent, sb.checked, nan_seen);
		$display("covered specials, ties, subnormals, huge exponent gaps and a long output stall");
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	initial begin
		#400000000;
		$display("DONE: errors detected");
		$finish;
	end
endmodule

### files.f
src/qfr_pkg.sv
src/quad_float_remainder_unit.sv
tb/quad_float_remainder_unit_tb.sv
